[rtl/core/mpsd_pkg.sv]
// ----------------------------------------------------------------------------
// mpsd_pkg
// Shared types and constants of the multi-press switch decoder: phase codes,
// channel payloads and register indexes.
// ----------------------------------------------------------------------------
package mpsd_pkg;

    // press count saturation limit (default of the top-level parameter)
    localparam int unsigned PULSE_MAX_DEF = 255;

    // field widths
    localparam int unsigned GAP_W    = 7;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned LIGHT_W  = 7;
    localparam int unsigned RGAP_W   = 6;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // tick counter limit while the switch is held
    localparam logic [GAP_W-1:0] PRESSED_MAX = 7'd100;

    // register reset values
    localparam logic [RGAP_W-1:0]  RELEASE_GAP_RST = 6'd5;
    localparam logic [LIGHT_W-1:0] LIGHT_TIME_RST  = 7'd100;

    // phase codes
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_PRESSED  = 2'd1;
    localparam logic [1:0] PH_RELEASED = 2'd2;
    localparam logic [1:0] PH_BAD      = 2'd3;

    // action codes that drive the backlight
    localparam logic [COUNT_W-1:0] ACT_REFRESH = 8'd1;
    localparam logic [COUNT_W-1:0] ACT_LIGHT   = 8'd2;
    localparam logic [COUNT_W-1:0] ACT_DARK    = 8'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_GAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_TIME  = 2'd1;

    typedef struct packed {
        logic switch_level;
    } sample_t;

    typedef struct packed {
        logic               action_valid;
        logic [COUNT_W-1:0] action_code;
        logic               light_on;
        logic [LIGHT_W-1:0] light_left;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

endpackage

[rtl/core/mpsd_chan_if.sv]
// ----------------------------------------------------------------------------
// mpsd_chan_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface mpsd_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/multi_press_switch_decoder.sv]
// A result is registered when its sample is accepted and is offered in the next cycle.
// Throughput: one sample per cycle; the state update is a single registered pass.
// A stalled result register holds back the input only while it stays full.
// Reset (rst_n low, asynchronous): phase idle, counters and light cleared,
// release_gap = 5, light_time = 100, no result pending.
// ----------------------------------------------------------------------------
// multi_press_switch_decoder
// Counts switch presses in a burst, reports the count when the release gap
// expires and runs a backlight timer driven by the reported actions.
// ----------------------------------------------------------------------------
module multi_press_switch_decoder #(
    parameter int unsigned PULSE_MAX = mpsd_pkg::PULSE_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mpsd_chan_if.sink   sample,
    mpsd_chan_if.source result,
    mpsd_chan_if.sink   cfg
);
    import mpsd_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(PULSE_MAX);

    logic [RGAP_W-1:0]  release_gap_reg;
    logic [LIGHT_W-1:0] light_time_reg;

    logic [1:0]         phase_reg,       phase_next;
    logic [GAP_W-1:0]   gap_reg,         gap_next;
    logic [COUNT_W-1:0] count_reg,       count_next;
    logic [LIGHT_W-1:0] light_ticks_reg, light_ticks_next;
    logic               light_lit_reg,   light_lit_next;

    logic               out_valid_reg;
    result_t            result_reg,      result_next;

    logic               accept;
    logic               pressed;
    logic [GAP_W-1:0]   gap_inc;
    logic               burst_done;
    logic [COUNT_W-1:0] code;
    logic [LIGHT_W-1:0] act_ticks;
    logic               act_lit;

    // handshakes
    assign sample.ready = !out_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    assign result.valid   = out_valid_reg;
    assign result.payload = result_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_gap_reg <= RELEASE_GAP_RST;
            light_time_reg  <= LIGHT_TIME_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.payload.index == REG_RELEASE_GAP)
            begin
                release_gap_reg <= cfg.payload.data[RGAP_W-1:0];
            end
            else if (cfg.payload.index == REG_LIGHT_TIME)
            begin
                light_time_reg <= cfg.payload.data[LIGHT_W-1:0];
            end
        end
    end

    // press phase machine
    assign pressed = !sample.payload.switch_level;
    assign gap_inc = gap_reg + GAP_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        gap_next   = gap_reg;
        count_next = count_reg;
        burst_done = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    phase_next = PH_PRESSED;
                    gap_next   = gap_inc;
                    count_next = COUNT_W'(1);
                end
            end
            PH_PRESSED:
            begin
                if (pressed)
                begin
                    gap_next = (gap_inc > PRESSED_MAX) ? PRESSED_MAX : gap_inc;
                end
                else
                begin
                    gap_next   = '0;
                    phase_next = PH_RELEASED;
                end
            end
            PH_RELEASED:
            begin
                if (pressed)
                begin
                    phase_next = PH_PRESSED;
                    gap_next   = '0;
                    if (count_reg < COUNT_LIMIT)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                else
                begin
                    gap_next = gap_inc;
                    if (gap_inc > GAP_W'(release_gap_reg))
                    begin
                        phase_next = PH_IDLE;
                        burst_done = 1'b1;
                        count_next = '0;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign code = burst_done ? count_reg : '0;

    // backlight action
    always_comb
    begin
        act_ticks = light_ticks_reg;
        act_lit   = light_lit_reg;
        if (burst_done)
        begin
            priority if (code == ACT_REFRESH)
            begin
                if (light_ticks_reg != '0)
                begin
                    act_lit   = 1'b1;
                    act_ticks = light_time_reg;
                end
            end
            else if (code == ACT_LIGHT)
            begin
                act_lit   = 1'b1;
                act_ticks = light_time_reg;
            end
            else if (code == ACT_DARK)
            begin
                act_lit   = 1'b0;
                act_ticks = '0;
            end
        end
    end

    // end-of-tick countdown
    always_comb
    begin
        if (act_ticks != '0)
        begin
            light_ticks_next = act_ticks - LIGHT_W'(1);
            light_lit_next   = act_lit;
        end
        else
        begin
            light_ticks_next = '0;
            light_lit_next   = 1'b0;
        end
    end

    always_comb
    begin
        result_next.action_valid = burst_done;
        result_next.action_code  = code;
        result_next.light_on     = light_lit_next;
        result_next.light_left   = light_ticks_next;
    end

    // state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            gap_reg         <= '0;
            count_reg       <= '0;
            light_ticks_reg <= '0;
            light_lit_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                gap_reg         <= gap_next;
                count_reg       <= count_next;
                light_ticks_reg <= light_ticks_next;
                light_lit_reg   <= light_lit_next;
                out_valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    // a completed burst always holds at least one press
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.action_valid |-> result_reg.action_code != '0)
        else $error("completed burst with zero presses");

    // no burst, no code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.action_valid |-> result_reg.action_code == '0)
        else $error("action code without completed burst");

    // a running timer means the light is lit
    assert property (@(posedge clk) disable iff (!rst_n)
        light_ticks_reg != '0 |-> light_lit_reg)
        else $error("backlight timer running while dark");

    // press count never passes its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_LIMIT)
        else $error("press count above limit");

    // the unused phase code is never entered
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_BAD)
        else $error("phase machine in unused code");

    // an accepted sample leaves a result pending in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted sample produced no result");

endmodule
